// ----- hdl/sse_pkg.sv -----
// Shared types, sizes and codes of the sorted set engine.
// No dependencies; every other file in hdl/ refers to it by scoped names.
`timescale 1ns / 1ps
`default_nettype none

package sse_pkg;

    localparam int SET_DEPTH   = 64;
    localparam int VALUE_WIDTH = 32;

    // Entry count must be able to hold SET_DEPTH itself
    localparam int CNT_W       = $clog2(SET_DEPTH + 1);
    localparam int IN_W        = 32;
    localparam int COUNT_OUT_W = 7;

    typedef logic signed [VALUE_WIDTH-1:0] value_t;
    typedef logic [CNT_W-1:0]              count_t;

    localparam logic [1:0] CMD_ADD    = 2'd0;
    localparam logic [1:0] CMD_REMOVE = 2'd1;
    localparam logic [1:0] CMD_SEARCH = 2'd2;

    localparam logic [1:0] OP_NONE = 2'd0;
    localparam logic [1:0] OP_INS  = 2'd1;
    localparam logic [1:0] OP_DEL  = 2'd2;

    // Compare wave moving along the chain
    typedef struct packed {
        logic tok;      // wave is at this link
        logic stopped;  // scan already stopped at or before this cell
        logic hit;      // stop point held an equal entry
    } link_t;

    // Broadcast from the controller to every cell
    typedef struct packed {
        logic [1:0] op;
        logic       descending;
        value_t     key;
    } cell_ctl_t;

endpackage

`default_nettype wire

// ----- hdl/sse_if.sv -----
// Valid/ready channel interfaces for requests and results.
// Depends on sse_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface sse_in_if;
    logic                              valid;
    logic                              ready;
    logic [1:0]                        cmd;
    logic signed [sse_pkg::IN_W-1:0]   elem_value;

    modport source (output valid, output cmd, output elem_value, input ready);
    modport sink   (input valid, input cmd, input elem_value, output ready);
endinterface

interface sse_out_if;
    logic                                valid;
    logic                                ready;
    logic                                success;
    logic                                full_reject;
    logic [sse_pkg::COUNT_OUT_W-1:0]     count_after;

    modport source (output valid, output success, output full_reject,
                    output count_after, input ready);
    modport sink   (input valid, input success, input full_reject,
                    input count_after, output ready);
endinterface

`default_nettype wire

// ----- hdl/sorted_set_engine_top.sv -----
// Top level of the sorted set engine: controller plus a chain of cells.
// Depends on sse_pkg, sse_if.sv, sse_cell and sse_ctrl.
`timescale 1ns / 1ps
`default_nettype none

// Keeps up to SET_DEPTH distinct signed values sorted in a row of cells,
// ascending or descending as the stored order bit selects (the user writes
// it through order_wr_en / order_wr_data while idle, which the block does
// not enforce; stored entries are not re-sorted). One request is handled at
// a time: after the request transfer a compare wave walks the chain one
// cell per clock, the UPDATE state then applies the shift, and result valid
// rises in the RESP state that follows. The next request is taken in the
// cycle after the result transfer, so receiver stalls delay it. Every
// request, including an unused command code, returns exactly one result
// with the new count.
module sorted_set_engine_top (
    input  wire logic clk,
    input  wire logic rst_n,
    sse_in_if.sink    in_ch,
    sse_out_if.source out_ch,
    input  wire logic order_wr_en,
    input  wire logic order_wr_data
);

    sse_pkg::cell_ctl_t ctl;
    sse_pkg::link_t     head_link;
    sse_pkg::count_t    count;
    sse_pkg::link_t     link  [sse_pkg::SET_DEPTH];
    sse_pkg::value_t    entry [sse_pkg::SET_DEPTH];
    logic [sse_pkg::SET_DEPTH-1:0] ge;
    logic [sse_pkg::SET_DEPTH-1:0] in_use;

    sse_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_ch         (in_ch),
        .out_ch        (out_ch),
        .order_wr_en   (order_wr_en),
        .order_wr_data (order_wr_data),
        .ctl           (ctl),
        .head_link     (head_link),
        .tail_link     (link[sse_pkg::SET_DEPTH-1]),
        .count         (count)
    );

    for (genvar k = 0; k < sse_pkg::SET_DEPTH; k++)
    begin : g_cell
        sse_pkg::link_t  lnk_in;
        sse_pkg::value_t left_e;
        sse_pkg::value_t right_e;
        logic            left_g;

        assign in_use[k] = (sse_pkg::count_t'(k) < count);

        if (k == 0)
        begin : g_first
            assign lnk_in = head_link;
            assign left_e = ctl.key;
            assign left_g = 1'b0;
        end
        else
        begin : g_mid
            assign lnk_in = link[k-1];
            assign left_e = entry[k-1];
            assign left_g = ge[k-1];
        end

        if (k == sse_pkg::SET_DEPTH - 1)
        begin : g_last
            assign right_e = entry[k];
        end
        else
        begin : g_inner
            assign right_e = entry[k+1];
        end

        sse_cell u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .ctl         (ctl),
            .in_use      (in_use[k]),
            .link_in     (lnk_in),
            .link_out    (link[k]),
            .left_entry  (left_e),
            .left_ge     (left_g),
            .right_entry (right_e),
            .entry       (entry[k]),
            .ge          (ge[k])
        );
    end

endmodule

`default_nettype wire

// ----- hdl/sse_cell.sv -----
// One storage cell of the sorted chain: holds one entry, evaluates the
// compare wave as it passes and shifts with its neighbors. Uses sse_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sse_cell (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire sse_pkg::cell_ctl_t ctl,
    input  wire logic               in_use,
    input  wire sse_pkg::link_t     link_in,
    output sse_pkg::link_t          link_out,
    input  wire sse_pkg::value_t    left_entry,
    input  wire logic               left_ge,
    input  wire sse_pkg::value_t    right_entry,
    output sse_pkg::value_t         entry,
    output logic                    ge
);

    sse_pkg::link_t  link_reg;
    sse_pkg::value_t entry_reg;
    sse_pkg::value_t entry_next;
    logic            ge_reg;
    logic            ge_next;
    logic            prec;
    logic            eq;
    logic            stop;

    always_comb
    begin
        eq   = (entry_reg == ctl.key);
        prec = ctl.descending ? (entry_reg >= ctl.key) : (entry_reg <= ctl.key);
        stop = !in_use || !prec || eq;

        link_out = '0;
        ge_next  = ge_reg;
        if (link_reg.tok)
        begin
            link_out.tok     = 1'b1;
            link_out.stopped = link_reg.stopped || stop;
            link_out.hit     = link_reg.hit || (!link_reg.stopped && in_use && eq);
            ge_next          = link_out.stopped;
        end
    end

    // ge marks cells at or past the stop point
    always_comb
    begin
        entry_next = entry_reg;
        case (ctl.op)
            sse_pkg::OP_INS:
            begin
                if (left_ge)
                    entry_next = left_entry;
                else if (ge_reg)
                    entry_next = ctl.key;
            end
            sse_pkg::OP_DEL:
            begin
                if (ge_reg)
                    entry_next = right_entry;
            end
            default: entry_next = entry_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            link_reg <= '0;
            ge_reg   <= 1'b0;
        end
        else
        begin
            link_reg <= link_in;
            ge_reg   <= ge_next;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;
    assign ge    = ge_reg;

endmodule

`default_nettype wire

// ----- hdl/sse_ctrl.sv -----
// Request sequencer: takes a request, launches the compare wave, applies
// the shift and returns the result. Uses sse_pkg, sse_in_if, sse_out_if.
`timescale 1ns / 1ps
`default_nettype none

module sse_ctrl (
    input  wire logic             clk,
    input  wire logic             rst_n,
    sse_in_if.sink                in_ch,
    sse_out_if.source             out_ch,
    input  wire logic             order_wr_en,
    input  wire logic             order_wr_data,
    output sse_pkg::cell_ctl_t    ctl,
    output sse_pkg::link_t        head_link,
    input  wire sse_pkg::link_t   tail_link,
    output sse_pkg::count_t       count
);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SCAN   = 2'd1;
    localparam logic [1:0] ST_UPDATE = 2'd2;
    localparam logic [1:0] ST_RESP   = 2'd3;

    logic [1:0]      state_reg, state_next;
    logic            desc_reg;
    logic [1:0]      cmd_reg;
    sse_pkg::value_t key_reg;
    logic            hit_reg, hit_next;
    sse_pkg::count_t count_reg, count_next;
    logic            success_reg, success_next;
    logic            full_reg, full_next;
    logic            in_xfer;
    logic            store_full;
    logic            do_ins;
    logic            do_del;

    assign in_xfer    = in_ch.valid && in_ch.ready;
    assign store_full = (count_reg == sse_pkg::count_t'(sse_pkg::SET_DEPTH));

    always_comb
    begin
        do_ins       = 1'b0;
        do_del       = 1'b0;
        success_next = success_reg;
        full_next    = full_reg;
        count_next   = count_reg;
        hit_next     = hit_reg;
        state_next   = state_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                    state_next = ST_SCAN;
            end
            ST_SCAN:
            begin
                if (tail_link.tok)
                begin
                    hit_next   = tail_link.hit;
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                success_next = 1'b0;
                full_next    = 1'b0;
                case (cmd_reg)
                    sse_pkg::CMD_ADD:
                    begin
                        do_ins       = !hit_reg && !store_full;
                        full_next    = !hit_reg && store_full;
                        success_next = do_ins;
                    end
                    sse_pkg::CMD_REMOVE:
                    begin
                        do_del       = hit_reg;
                        success_next = hit_reg;
                    end
                    sse_pkg::CMD_SEARCH: success_next = hit_reg;
                    default:             success_next = 1'b0;
                endcase
                if (do_ins)
                    count_next = count_reg + 1'b1;
                else if (do_del)
                    count_next = count_reg - 1'b1;
                state_next = ST_RESP;
            end
            ST_RESP:
            begin
                if (out_ch.ready)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            desc_reg    <= 1'b0;
            count_reg   <= '0;
            hit_reg     <= 1'b0;
            success_reg <= 1'b0;
            full_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            hit_reg     <= hit_next;
            success_reg <= success_next;
            full_reg    <= full_next;
            if (order_wr_en)
                desc_reg <= order_wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            cmd_reg <= in_ch.cmd;
            key_reg <= sse_pkg::value_t'(in_ch.elem_value);
        end
    end

    always_comb
    begin
        ctl.descending = desc_reg;
        ctl.key        = key_reg;
        ctl.op         = do_ins ? sse_pkg::OP_INS :
                         do_del ? sse_pkg::OP_DEL : sse_pkg::OP_NONE;
    end

    // Wave enters cell 0 together with the request key
    always_comb
    begin
        head_link         = '0;
        head_link.tok     = in_xfer;
    end

    assign in_ch.ready        = (state_reg == ST_IDLE);
    assign out_ch.valid       = (state_reg == ST_RESP);
    assign out_ch.success     = success_reg;
    assign out_ch.full_reject = full_reg;
    assign out_ch.count_after = sse_pkg::COUNT_OUT_W'(count_reg);
    assign count              = count_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= sse_pkg::count_t'(sse_pkg::SET_DEPTH))
        else $error("entry count beyond depth");

    a_result_excl: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid |-> !(out_ch.success && out_ch.full_reject))
        else $error("result both successful and rejected as full");

    a_ins_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_UPDATE && do_ins) |=>
            (count_reg == sse_pkg::count_t'($past(count_reg) + 1'b1)))
        else $error("insert did not bump count");

    a_wave_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        tail_link.tok |-> (state_reg == ST_SCAN))
        else $error("compare wave left chain outside scan");

endmodule

`default_nettype wire
